>>> rtl/core/base64url_encoder_core_defines.svh
// ---------------------------------------------------------------------------
// base64url encoder core assertion macros
// Concurrent check wrappers, compiled away when SYNTHESIS is defined.
// Expects signals named clock and reset in the enclosing module.
// ---------------------------------------------------------------------------
`ifndef BASE64URL_ENCODER_CORE_DEFINES_SVH
`define BASE64URL_ENCODER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define B64_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("b64 same-cycle check failed");
// next-cycle implication
`define B64_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("b64 next-cycle check failed");
`else
`define B64_ASSERT_IMPLY(label, ante, cons)
`define B64_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> rtl/core/b64url_pkg.sv
// ---------------------------------------------------------------------------
// b64url_pkg
// Shared word types, group type and alphabet lookup for the base64url encoder.
// ---------------------------------------------------------------------------
`default_nettype none

package b64url_pkg;

   localparam int unsigned GROUP_W = 24;
   localparam logic [6:0]  PAD_CHAR = 7'h3d;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_message;
   } req_type;

   typedef struct packed {
      logic [6:0] out_char;
      logic       final_char;
   } rsp_type;

   // one released group: up to three bytes, number of pad chars, last flag
   typedef struct packed {
      logic [GROUP_W-1:0] bits;
      logic [1:0]         pad_cnt;
      logic               last;
   } grp_type;

   function automatic logic [6:0] b64_sym(input logic [5:0] v);
      logic [6:0] v7;
      v7 = {1'b0, v};
      if (v < 6'd26) begin
         return 7'h41 + v7;
      end else if (v < 6'd52) begin
         return 7'h61 + v7 - 7'd26;
      end else if (v < 6'd62) begin
         return 7'h30 + v7 - 7'd52;
      end else if (v == 6'd62) begin
         return 7'h2d;
      end else begin
         return 7'h5f;
      end
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/b64_fifo.sv
// ---------------------------------------------------------------------------
// b64_fifo
// Small register queue of released groups between the front and back parts.
// ---------------------------------------------------------------------------
`default_nettype none
`include "base64url_encoder_core_defines.svh"

module b64_fifo import b64url_pkg::*; #(
   parameter int unsigned DEPTH = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_push,
   input  grp_type wr_data,
   output logic    wr_full,
   input  logic    rd_pop,
   output grp_type rd_data,
   output logic    rd_empty
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   grp_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   assign wr_full  = (count_ff == CNT_W'(DEPTH));
   assign rd_empty = (count_ff == '0);
   assign rd_data  = mem_ff[rd_ptr_ff];
   assign do_wr    = wr_push & ~wr_full;
   assign do_rd    = rd_pop & ~rd_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   `B64_ASSERT_IMPLY(a_fifo_count_bound, 1'b1, count_ff <= CNT_W'(DEPTH))
   `B64_ASSERT_IMPLY(a_fifo_ptrs_match, count_ff == '0, wr_ptr_ff == rd_ptr_ff)

endmodule

`default_nettype wire

>>> rtl/core/b64_front.sv
// ---------------------------------------------------------------------------
// b64_front
// Takes input bytes, holds up to two of them and releases full or padded
// three-byte groups to the group queue.
// ---------------------------------------------------------------------------
`default_nettype none
`include "base64url_encoder_core_defines.svh"

module b64_front import b64url_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  req_type req_data,
   output logic    req_full,
   output logic    grp_push,
   output grp_type grp,
   input  logic    grp_full
);

   logic [1:0] cnt_ff, cnt_in;
   logic [7:0] b0_ff, b0_in;
   logic [7:0] b1_ff, b1_in;
   logic       accept;
   logic       release_grp;
   logic [7:0] b;
   logic       eom;

   assign req_full = grp_full;
   assign accept   = req_push & ~grp_full;
   assign b        = req_data.data_byte;
   assign eom      = req_data.end_of_message;
   assign grp_push = accept & release_grp;

   always_comb begin
      cnt_in      = cnt_ff;
      b0_in       = b0_ff;
      b1_in       = b1_ff;
      release_grp = 1'b0;
      grp         = '{bits: '0, pad_cnt: 2'd0, last: 1'b0};
      case (cnt_ff)
         2'd1: begin
            if (eom) begin
               release_grp = 1'b1;
               grp = '{bits: {b0_ff, b, 8'h00}, pad_cnt: 2'd1, last: 1'b1};
               cnt_in = 2'd0;
            end else begin
               b1_in  = b;
               cnt_in = 2'd2;
            end
         end
         2'd2: begin
            release_grp = 1'b1;
            grp = '{bits: {b0_ff, b1_ff, b}, pad_cnt: 2'd0, last: eom};
            cnt_in = 2'd0;
         end
         default: begin
            // empty holding register
            if (eom) begin
               release_grp = 1'b1;
               grp = '{bits: {b, 16'h0000}, pad_cnt: 2'd2, last: 1'b1};
               cnt_in = 2'd0;
            end else begin
               b0_in  = b;
               cnt_in = 2'd1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else if (accept) begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b0_ff <= b0_in;
         b1_ff <= b1_in;
      end
   end

   `B64_ASSERT_IMPLY(a_front_cnt_range, 1'b1, cnt_ff != 2'd3)
   `B64_ASSERT_NEXT(a_front_release_clears, grp_push, cnt_ff == 2'd0)

endmodule

`default_nettype wire

>>> rtl/core/b64_back.sv
// ---------------------------------------------------------------------------
// b64_back
// Pulls groups from the queue and emits their four characters one word
// per cycle while rsp_pop is high, with pad and final-character marking.
// ---------------------------------------------------------------------------
`default_nettype none
`include "base64url_encoder_core_defines.svh"

module b64_back import b64url_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_empty,
   input  grp_type q_data,
   output logic    q_pop,
   output logic    rsp_empty,
   output rsp_type rsp_data,
   input  logic    rsp_pop
);

   grp_type    cur_ff, cur_in;
   logic       busy_ff, busy_in;
   logic [1:0] idx_ff, idx_in;
   logic       take;
   logic       done;
   logic       load;
   logic [5:0] sext;
   logic       pad;

   assign take      = rsp_pop & busy_ff;
   assign done      = take & (idx_ff == 2'd3);
   assign load      = ~q_empty & (~busy_ff | done);
   assign q_pop     = load;
   assign rsp_empty = ~busy_ff;

   always_comb begin
      cur_in  = cur_ff;
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (load) begin
         cur_in  = q_data;
         busy_in = 1'b1;
         idx_in  = 2'd0;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (take) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_comb begin
      case (idx_ff)
         2'd0:    sext = cur_ff.bits[23:18];
         2'd1:    sext = cur_ff.bits[17:12];
         2'd2:    sext = cur_ff.bits[11:6];
         default: sext = cur_ff.bits[5:0];
      endcase
      // pads fill the tail of a short group
      pad = ((idx_ff == 2'd3) && (cur_ff.pad_cnt != 2'd0)) ||
            ((idx_ff == 2'd2) && (cur_ff.pad_cnt == 2'd2));
      rsp_data.out_char   = pad ? PAD_CHAR : b64_sym(sext);
      rsp_data.final_char = cur_ff.last & (idx_ff == 2'd3);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   `B64_ASSERT_IMPLY(a_back_pad_slot, busy_ff && rsp_data.out_char == PAD_CHAR, idx_ff[1])
   `B64_ASSERT_NEXT(a_back_drain, done && q_empty, !busy_ff)

endmodule

`default_nettype wire

>>> rtl/core/base64url_encoder_core.sv
// ---------------------------------------------------------------------------
// base64url_encoder_core
// Streaming Base64 encoder, URL-safe alphabet with '=' padding.
// ---------------------------------------------------------------------------
// Bytes enter one word per cycle while req_full is low; the front holds up
// to two bytes and hands each full or end-of-message group to a queue of
// QUEUE_DEPTH groups. The back emits four characters per group, one word
// per cycle while rsp_pop is high, so its single character output sets the
// sustained input rate; with the back idle, a group-completing byte passes
// through the queue and the back's group register before its first
// character shows. The last character of a message carries final_char.
`default_nettype none

module base64url_encoder_core import b64url_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  req_type req_data,
   output logic    req_full,
   output logic    rsp_empty,
   output rsp_type rsp_data,
   input  logic    rsp_pop
);

   logic    grp_push;
   grp_type grp;
   logic    grp_full;
   logic    q_pop;
   grp_type q_data;
   logic    q_empty;

   b64_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .grp_push (grp_push),
      .grp      (grp),
      .grp_full (grp_full)
   );

   b64_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_push  (grp_push),
      .wr_data  (grp),
      .wr_full  (grp_full),
      .rd_pop   (q_pop),
      .rd_data  (q_data),
      .rd_empty (q_empty)
   );

   b64_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data),
      .rsp_pop   (rsp_pop)
   );

endmodule

`default_nettype wire

>>> tb/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for base64url_encoder_core: messages of raw bytes go in
// through the push side, and every character that comes out is compared with
// a local encoder, with random gaps on both sides.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import b64url_pkg::*;

   localparam int unsigned ITEM_TARGET = 460;
   localparam int unsigned IDLE_LIMIT  = 2000;
   localparam int unsigned DRAIN_EVERY = 120;
   localparam int unsigned TAIL_CYCLES = 20;

   logic    clock;
   logic    reset;
   logic    req_push;
   req_type req_data;
   logic    req_full;
   logic    rsp_empty;
   rsp_type rsp_data;
   logic    rsp_pop;

   string alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

   req_type     byte_queue[$];
   rsp_type     expected_chars[$];
   logic [15:0] held_bytes;
   logic [1:0]  held_cnt;
   int unsigned sent_cnt;
   int unsigned predicted_cnt;
   int unsigned checked_cnt;
   int unsigned error_cnt;
   int unsigned send_gap;
   int unsigned pop_gap;
   int unsigned idle_cnt;
   logic [31:0] cycle_cnt;

   base64url_encoder_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data),
      .rsp_pop   (rsp_pop)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [6:0] url_char(input logic [5:0] v);
      logic [7:0] c;
      c = alphabet[v];
      return c[6:0];
   endfunction

   function automatic void expect_char(input logic [6:0] c, input logic fin);
      rsp_type w;
      w.out_char   = c;
      w.final_char = fin;
      expected_chars.push_back(w);
   endfunction

   // encodes one accepted byte and queues the characters it releases
   function automatic int unsigned encode_byte(input req_type w);
      logic [7:0] b;
      logic [7:0] b0;
      logic [7:0] b1;
      b  = w.data_byte;
      b0 = held_bytes[7:0];
      b1 = held_bytes[15:8];
      if (held_cnt == 2'd2) begin
         expect_char(url_char(b0[7:2]), 1'b0);
         expect_char(url_char({b0[1:0], b1[7:4]}), 1'b0);
         expect_char(url_char({b1[3:0], b[7:6]}), 1'b0);
         expect_char(url_char(b[5:0]), w.end_of_message);
      end else if (!w.end_of_message) begin
         if (held_cnt == 2'd1) begin
            held_bytes[15:8] = b;
            held_cnt = 2'd2;
         end else begin
            held_bytes = {8'h00, b};
            held_cnt = 2'd1;
         end
         return 0;
      end else if (held_cnt == 2'd1) begin
         expect_char(url_char(b0[7:2]), 1'b0);
         expect_char(url_char({b0[1:0], b[7:4]}), 1'b0);
         expect_char(url_char({b[3:0], 2'b00}), 1'b0);
         expect_char(PAD_CHAR, 1'b1);
      end else begin
         expect_char(url_char(b[7:2]), 1'b0);
         expect_char(url_char({b[1:0], 4'h0}), 1'b0);
         expect_char(PAD_CHAR, 1'b0);
         expect_char(PAD_CHAR, 1'b1);
      end
      held_bytes = 16'h0000;
      held_cnt = 2'd0;
      return 4;
   endfunction

   // mostly short gaps, a few long ones, none in quiet stretches
   function automatic int unsigned pick_gap(input logic quiet);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) begin
         return 0;
      end else if (r < 92) begin
         return $urandom_range(1, 3);
      end else begin
         return $urandom_range(4, 20);
      end
   endfunction

   function automatic logic [7:0] rand_byte();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0) begin
         return 8'h00;
      end else if (r == 1) begin
         return 8'hff;
      end else begin
         return 8'($urandom_range(0, 255));
      end
   endfunction

   function automatic void add_word(input logic [7:0] b, input logic eom);
      req_type w;
      w.data_byte      = b;
      w.end_of_message = eom;
      byte_queue.push_back(w);
   endfunction

   // sender: presents words from byte_queue, predicts on each accepted word
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_push && !req_full) begin
            predicted_cnt = predicted_cnt + encode_byte(req_data);
            sent_cnt = sent_cnt + 1;
         end
         if (!req_push || !req_full) begin
            if (send_gap != 0) begin
               send_gap <= send_gap - 1;
               req_push <= 1'b0;
            end else if (sent_cnt != 0 && sent_cnt % DRAIN_EVERY == 0 &&
                         predicted_cnt != checked_cnt) begin
               // hold off until the output side has caught up
               req_push <= 1'b0;
            end else if (byte_queue.size() == 0) begin
               req_push <= 1'b0;
            end else begin
               req_data <= byte_queue.pop_front();
               req_push <= 1'b1;
               send_gap <= pick_gap(cycle_cnt[8:7] == 2'd0);
            end
         end
      end
   end

   // receiver: random pop stalls, checks each accepted word
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
         pop_gap <= 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            checked_cnt <= checked_cnt + 1;
            if (expected_chars.size() == 0) begin
               $display("%0t: unexpected word, expected none, got char %h final %b",
                        $time, rsp_data.out_char, rsp_data.final_char);
               error_cnt = error_cnt + 1;
            end else begin
               want = expected_chars.pop_front();
               if (rsp_data.out_char !== want.out_char) begin
                  $display("%0t: out_char expected %h got %h",
                           $time, want.out_char, rsp_data.out_char);
                  error_cnt = error_cnt + 1;
               end
               if (rsp_data.final_char !== want.final_char) begin
                  $display("%0t: final_char expected %b got %b",
                           $time, want.final_char, rsp_data.final_char);
                  error_cnt = error_cnt + 1;
               end
            end
         end
         if (pop_gap != 0) begin
            pop_gap <= pop_gap - 1;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
            if (rsp_pop) begin
               pop_gap <= pick_gap(cycle_cnt[8:7] == 2'd1);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (reset) begin
         idle_cnt <= 0;
      end else if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cnt <= 0;
      end else if (idle_cnt >= IDLE_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, idle_cnt);
         $display("FAILED: results differ");
         $finish;
      end else begin
         idle_cnt <= idle_cnt + 1;
      end
   end

   initial begin
      int unsigned msg_len;
      int unsigned total;
      reset         = 1'b1;
      req_push      = 1'b0;
      req_data      = '0;
      rsp_pop       = 1'b0;
      held_bytes    = 16'h0000;
      held_cnt      = 2'd0;
      sent_cnt      = 0;
      predicted_cnt = 0;
      checked_cnt   = 0;
      error_cnt     = 0;
      cycle_cnt     = 0;

      // single byte messages at both extremes
      add_word(8'h00, 1'b1);
      add_word(8'hff, 1'b1);
      // two byte messages
      add_word(8'h00, 1'b0);
      add_word(8'h00, 1'b1);
      add_word(8'hff, 1'b0);
      add_word(8'hff, 1'b1);
      // full group not marked last, then more of the same message
      add_word(8'h00, 1'b0);
      add_word(8'h10, 1'b0);
      add_word(8'h83, 1'b0);
      add_word(8'hfb, 1'b0);
      add_word(8'hef, 1'b0);
      add_word(8'hbe, 1'b1);
      // full groups, all ones then all zeros marked last
      add_word(8'hff, 1'b0);
      add_word(8'hff, 1'b0);
      add_word(8'hff, 1'b0);
      add_word(8'h00, 1'b0);
      add_word(8'h00, 1'b0);
      add_word(8'h00, 1'b1);
      add_word(8'haa, 1'b0);
      add_word(8'h55, 1'b1);
      add_word(8'h5a, 1'b1);

      while (byte_queue.size() < ITEM_TARGET) begin
         if ($urandom_range(0, 9) == 0) begin
            msg_len = $urandom_range(13, 40);
         end else begin
            msg_len = $urandom_range(1, 12);
         end
         for (int unsigned k = 0; k < msg_len; k++) begin
            add_word(rand_byte(), k == msg_len - 1);
         end
      end
      total = byte_queue.size();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      do begin
         @(negedge clock);
      end while (sent_cnt < total || predicted_cnt != checked_cnt);
      repeat (TAIL_CYCLES) @(negedge clock);

      if (expected_chars.size() != 0) begin
         $display("%0t: %0d expected words never arrived, next char %h final %b",
                  $time, expected_chars.size(), expected_chars[0].out_char,
                  expected_chars[0].final_char);
         error_cnt = error_cnt + 1;
      end
      if (error_cnt == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/b64url_pkg.sv
rtl/core/b64_fifo.sv
rtl/core/b64_front.sv
rtl/core/b64_back.sv
rtl/core/base64url_encoder_core.sv
tb/tb.sv
